// ===== rtl/core/tdi3_pkg.sv =====
// Shared types, widths and codes for the three-axis trapezoid dead-reckoning core.
// Used by tdi3_lane, tdi3_merge and trapezoid_double_integrator_3axis_core.
package tdi3_pkg;

    // Axis count and default acceleration width
    localparam int NUM_AXES        = 3;
    localparam int ACCEL_WIDTH_DEF = 16;

    // Fixed field and state widths
    localparam int ACC_FIELD_W = 16;
    localparam int DT_W        = 16;
    localparam int VEL_W       = 48;
    localparam int POS_W       = 64;
    localparam int POS_SHIFT   = 17;

    // Configuration reset value (about 0.05 s in Q0.16)
    localparam logic [DT_W-1:0] DT_RESET = 16'd3277;

    // Stream payload layout
    localparam int IN_DATA_W  = 56;
    localparam int RUN_BIT    = 3 * ACC_FIELD_W;
    localparam int CLEAR_BIT  = 3 * ACC_FIELD_W + 1;
    localparam int OUT_DATA_W = 200;
    localparam int SAT_BIT    = NUM_AXES * POS_W;

    // Item kinds carried in tuser
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_CONTROL = 1'b1;

    // Per-lane step strobes from the sequencer
    typedef struct packed {
        logic load;
        logic clear;
        logic mul_a;
        logic vel;
        logic sum_v;
        logic mul_v;
        logic commit;
    } t_lane_ctl;

    // Per-lane state seen by the merge stage
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic                    sat;
    } t_lane_res;

endpackage

// ===== rtl/core/tdi3_lane.sv =====
// One axis of the trapezoid double integrator: accel history, velocity, position.
// Steps through multiply, velocity update, sum, multiply and position update.
// Depends on tdi3_pkg.
module tdi3_lane
    import tdi3_pkg::*;
#(
    parameter int ACCEL_WIDTH = ACCEL_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lane_ctl              i_ctl,
    input  logic [ACC_FIELD_W-1:0] i_accel,
    input  logic [DT_W-1:0]        i_step_dt,
    output t_lane_res              o_res
);

    localparam int W     = ACCEL_WIDTH;
    localparam int EXT_W = (W > ACC_FIELD_W) ? W : ACC_FIELD_W;
    localparam int SA_W  = W + 1;
    localparam int PA_W  = SA_W + DT_W;
    localparam int DV_W  = PA_W - 1;
    localparam int VS_W  = ((VEL_W > DV_W + 1) ? VEL_W : DV_W + 1) + 1;
    localparam int SV_W  = VEL_W + 1;
    localparam int PV_W  = SV_W + DT_W;
    localparam int DP_W  = PV_W - POS_SHIFT;
    localparam int PS_W  = POS_W + 2;

    // Integration state
    logic signed [W-1:0]     r_last_accel;
    logic signed [VEL_W-1:0] r_vel;
    logic signed [POS_W-1:0] r_pos;
    logic                    r_sat;

    // Per-item working registers
    logic signed [W-1:0]     r_accel;
    logic [PA_W-1:0]         r_prod_a;
    logic                    r_neg_a;
    logic signed [VEL_W-1:0] r_vel_new;
    logic [SV_W-1:0]         r_mag_v;
    logic                    r_neg_v;
    logic [PV_W-1:0]         r_prod_v;

    logic [EXT_W-1:0]        w_accel_ext;
    logic signed [W-1:0]     w_accel;
    logic signed [SA_W-1:0]  w_sum_a;
    logic [SA_W-1:0]         w_mag_a;
    logic [DV_W-1:0]         w_dv;
    logic signed [VS_W-1:0]  w_dv_s;
    logic signed [VS_W-1:0]  w_vel_sum;
    logic                    w_vel_ovf;
    logic signed [VEL_W-1:0] w_vel_clip;
    logic signed [SV_W-1:0]  w_sum_v;
    logic [DP_W-1:0]         w_dp;
    logic signed [PS_W-1:0]  w_dp_s;
    logic signed [PS_W-1:0]  w_pos_sum;
    logic                    w_pos_ovf;
    logic signed [POS_W-1:0] w_pos_clip;

    // Take the low ACCEL_WIDTH bits of the field as two's complement
    assign w_accel_ext = EXT_W'(i_accel);
    assign w_accel     = $signed(w_accel_ext[W-1:0]);

    // Accel sum and its magnitude
    assign w_sum_a = SA_W'(r_last_accel) + SA_W'(r_accel);
    assign w_mag_a = w_sum_a[SA_W-1] ? SA_W'(-w_sum_a) : SA_W'(w_sum_a);

    // Velocity delta, rounded half away from zero, and clipped velocity
    assign w_dv       = DV_W'((r_prod_a + PA_W'(1)) >> 1);
    assign w_dv_s     = r_neg_a ? -$signed(VS_W'(w_dv)) : $signed(VS_W'(w_dv));
    assign w_vel_sum  = VS_W'(r_vel) + w_dv_s;
    assign w_vel_ovf  = (w_vel_sum[VS_W-1:VEL_W-1] != {(VS_W-VEL_W+1){1'b0}}) &&
                        (w_vel_sum[VS_W-1:VEL_W-1] != {(VS_W-VEL_W+1){1'b1}});
    assign w_vel_clip = !w_vel_ovf ? w_vel_sum[VEL_W-1:0] :
                        (w_vel_sum[VS_W-1] ? {1'b1, {(VEL_W-1){1'b0}}}
                                           : {1'b0, {(VEL_W-1){1'b1}}});

    // Old plus new velocity
    assign w_sum_v = SV_W'(r_vel) + SV_W'(r_vel_new);

    // Position delta, rounded half away from zero, and clipped position
    assign w_dp       = DP_W'((r_prod_v + (PV_W'(1) << (POS_SHIFT - 1))) >> POS_SHIFT);
    assign w_dp_s     = r_neg_v ? -$signed(PS_W'(w_dp)) : $signed(PS_W'(w_dp));
    assign w_pos_sum  = PS_W'(r_pos) + w_dp_s;
    assign w_pos_ovf  = (w_pos_sum[PS_W-1:POS_W-1] != 3'b000) &&
                        (w_pos_sum[PS_W-1:POS_W-1] != 3'b111);
    assign w_pos_clip = !w_pos_ovf ? w_pos_sum[POS_W-1:0] :
                        (w_pos_sum[PS_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                           : {1'b0, {(POS_W-1){1'b1}}});

    // Integration state: clear, restart the clip flag on load, flag clips, commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_accel <= '0;
            r_vel        <= '0;
            r_pos        <= '0;
            r_sat        <= 1'b0;
        end else if (i_ctl.clear) begin
            r_last_accel <= '0;
            r_vel        <= '0;
            r_pos        <= '0;
            r_sat        <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_sat <= 1'b0;
            end else if (i_ctl.vel) begin
                r_sat <= r_sat | w_vel_ovf;
            end else if (i_ctl.commit) begin
                r_sat        <= r_sat | w_pos_ovf;
                r_pos        <= w_pos_clip;
                r_vel        <= r_vel_new;
                r_last_accel <= r_accel;
            end
        end
    end

    // Working registers, one step per strobe
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_accel <= w_accel;
        end
        if (i_ctl.mul_a) begin
            r_prod_a <= PA_W'(w_mag_a) * PA_W'(i_step_dt);
            r_neg_a  <= w_sum_a[SA_W-1];
        end
        if (i_ctl.vel) begin
            r_vel_new <= w_vel_clip;
        end
        if (i_ctl.sum_v) begin
            r_mag_v <= w_sum_v[SV_W-1] ? SV_W'(-w_sum_v) : SV_W'(w_sum_v);
            r_neg_v <= w_sum_v[SV_W-1];
        end
        if (i_ctl.mul_v) begin
            r_prod_v <= PV_W'(r_mag_v) * PV_W'(i_step_dt);
        end
    end

    assign o_res.pos = r_pos;
    assign o_res.sat = r_sat;

endmodule

// ===== rtl/core/tdi3_merge.sv =====
// Merge stage: combines the lane positions and clip flags into one result
// transaction and holds it in the output register. Depends on tdi3_pkg.
module tdi3_merge
    import tdi3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_lane_res             i_res [NUM_AXES],
    output logic                  o_free,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // fields from bit 0: pos_x[63:0], pos_y, pos_z, saturated, zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;
    logic                  w_any_sat;
    logic [OUT_DATA_W-1:0] w_packed;

    // Combine the lane clip flags
    always_comb begin
        w_any_sat = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            w_any_sat = w_any_sat | i_res[i].sat;
        end
    end

    // Pack positions and flag
    always_comb begin
        w_packed = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            w_packed[i*POS_W +: POS_W] = i_res[i].pos;
        end
        w_packed[SAT_BIT] = w_any_sat;
    end

    assign o_free = !r_valid || i_m_axis_tready;

    // Output register valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload: hold until the next load
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= w_packed;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

endmodule

// ===== rtl/core/trapezoid_double_integrator_3axis_core.sv =====
// Three-axis trapezoid dead-reckoning core: one lane per axis, a sequencer
// and a merge stage. Depends on tdi3_pkg, tdi3_lane and tdi3_merge.
// Results: a sample while running passes through the six sequencer steps (two multiplies,
// velocity, sum, position, output) and is loaded into the output register in the output
// step; a control with clear goes straight to the output step; other items give none and
// leave the sequencer idle. A new item is taken only while the sequencer is idle, so a sample
// must finish before the next item is accepted; a held result stalls the sequencer in its output step.
// Reset: velocity, accel history, position cleared, stopped, time step 3277.
module trapezoid_double_integrator_3axis_core
    import tdi3_pkg::*;
#(
    parameter int ACCEL_WIDTH = ACCEL_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // fields from bit 0: accel_x[15:0], accel_y, accel_z, run_enable, clear_state, zero fill
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // fields from bit 0: operation
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // fields from bit 0: pos_x[63:0], pos_y, pos_z, saturated, zero fill
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [DT_W-1:0]       i_cfg_data
);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL_A = 3'd1;
    localparam logic [2:0] S_VEL   = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_MUL_V = 3'd4;
    localparam logic [2:0] S_POS   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic            r_running;
    logic            n_running;
    logic [DT_W-1:0] r_step_dt;

    logic            w_in_acc;
    logic            w_is_ctl;
    logic            w_out_free;
    logic            w_out_load;
    t_lane_ctl       w_ctl;
    t_lane_res       w_res [NUM_AXES];

    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_is_ctl        = (i_s_axis_tuser == OP_CONTROL);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;

    // Time step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_dt <= DT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_step_dt <= i_cfg_data;
        end
    end

    // Next state and run flag
    always_comb begin
        n_state   = r_state;
        n_running = r_running;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_is_ctl) begin
                        n_running = i_s_axis_tdata[RUN_BIT];
                        if (i_s_axis_tdata[CLEAR_BIT]) begin
                            n_state = S_OUT;
                        end
                    end else if (r_running) begin
                        n_state = S_MUL_A;
                    end
                end
            end
            S_MUL_A: n_state = S_VEL;
            S_VEL:   n_state = S_SUM;
            S_SUM:   n_state = S_MUL_V;
            S_MUL_V: n_state = S_POS;
            S_POS:   n_state = S_OUT;
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_running <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_running <= n_running;
        end
    end

    // Lane strobes
    assign w_ctl.load   = w_in_acc && !w_is_ctl && r_running;
    assign w_ctl.clear  = w_in_acc && w_is_ctl && i_s_axis_tdata[CLEAR_BIT];
    assign w_ctl.mul_a  = (r_state == S_MUL_A);
    assign w_ctl.vel    = (r_state == S_VEL);
    assign w_ctl.sum_v  = (r_state == S_SUM);
    assign w_ctl.mul_v  = (r_state == S_MUL_V);
    assign w_ctl.commit = (r_state == S_POS);
    assign w_out_load   = (r_state == S_OUT) && w_out_free;

    // One lane per axis
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        tdi3_lane #(
            .ACCEL_WIDTH (ACCEL_WIDTH)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_accel     (i_s_axis_tdata[g*ACC_FIELD_W +: ACC_FIELD_W]),
            .i_step_dt   (r_step_dt),
            .o_res       (w_res[g])
        );
    end

    // Merge lanes into the output register
    tdi3_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_out_load),
        .i_res           (w_res),
        .o_free          (w_out_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // A sample taken while stopped leaves the sequencer idle
    a_stopped_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_is_ctl && !r_running) |=> (r_state == S_IDLE))
        else $error("sample while stopped started the sequencer");

    // A clear zeroes every lane position before the result is loaded
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.clear |=> (r_state == S_OUT && w_res[0].pos == '0 &&
                         w_res[1].pos == '0 && w_res[2].pos == '0 && !w_res[0].sat))
        else $error("clear did not zero lane state");

    // Loading a result always presents it on the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_m_axis_tvalid)
        else $error("loaded result not presented");

    // Position update is always followed by the result step
    a_pos_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POS) |=> (r_state == S_OUT))
        else $error("position step not followed by result step");

endmodule
